[hdl/asrb_pkg.sv]
`default_nettype none
package asrb_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int DIST_W   = 14;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_GET_DIST = 2'd2,
    OP_SET_DIST = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample_in;
    logic [DIST_W-1:0]   distance;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic [DIST_W-1:0]   fill_distance;
    logic                underrun;
    logic                overrun;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // capture the input item
    logic exec;   // pointer update and memory access
    logic load;   // fill the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage
`default_nettype wire

[hdl/audio_sample_ring_buffer_top.sv]
`default_nettype none
// Channel  | Ports                        | Direction
// ---------+------------------------------+----------
// input    | in_valid, in_stall, in_data   | in
// result   | out_valid, out_stall, out_data| out
//
// Each item is captured, then runs the pointer update and the single memory
// access; the result loads into the output register as the next item is
// captured. No item enters while one executes; the next may enter as the
// last result loads, paced by the controller's capture-execute sequence.
// Reset (rst_n low, synchronous) clears pointers, sets underrun, clears the
// other flags; no clearing pass: the wrap flag and write pointer mark which
// entries have been written. A stalled result holds in_stall high and keeps
// the next result waiting to load until the output register frees.
module audio_sample_ring_buffer_top #(
  parameter int DEPTH = 16384
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire asrb_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output asrb_pkg::out_item_t     out_data
);
  import asrb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  asrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[hdl/asrb_ctrl.sv]
`default_nettype none
module asrb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire asrb_pkg::sts_t sts,
  output asrb_pkg::cmd_t     cmd
);
  import asrb_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands; a new item may enter while the last result loads
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.take  = 1'b1;
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/asrb_dp.sv]
`default_nettype none
module asrb_dp #(
  parameter int DEPTH = 16384
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire asrb_pkg::cmd_t     cmd,
  output asrb_pkg::sts_t          sts,
  input  wire asrb_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output asrb_pkg::out_item_t     out_data
);
  import asrb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (PW > DIST_W) ? PW : DIST_W;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_X = (PW+1)'(DEPTH);

  // Sample store
  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Captured item
  op_t                 op_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [DIST_W-1:0]   dist_r;

  // Pointers and flags
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic          und_r, und_nxt;
  logic          ovr_r, ovr_nxt;
  // Set once the write pointer has wrapped: every entry has then been written
  logic          lap_r, lap_nxt;

  logic [SAMPLE_W-1:0] rd_r;
  logic                rd_ok_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [PW-1:0] wp_adv, eff, eff_adv, dist_p, set_rp, fill;
  logic [XW-1:0] dist_x, fill_x;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  // Modular difference a - b over DEPTH
  function automatic logic [PW-1:0] mdiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] t;
    t = {1'b0, a} + DEPTH_X - {1'b0, b};
    return (a >= b) ? a - b : t[PW-1:0];
  endfunction

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_data.op;
      smp_r  <= in_data.sample_in;
      dist_r <= in_data.distance;
    end
  end

  // Pointer arithmetic
  always_comb begin
    wp_adv  = adv(wp_r);
    eff     = ovr_r ? wp_r : rp_r;
    eff_adv = adv(eff);
    dist_x  = XW'(dist_r);
    dist_p  = (dist_x > XW'(DEPTH - 1)) ? LAST : dist_x[PW-1:0];
    set_rp  = mdiff(wp_r, dist_p);
    fill    = mdiff(wp_r, rp_r);
    fill_x  = XW'(fill);
  end

  // Next pointer and flag values
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    und_nxt = und_r;
    ovr_nxt = ovr_r;
    lap_nxt = lap_r;
    if (cmd.exec) begin
      case (op_r)
        OP_PUSH: begin
          wp_nxt  = wp_adv;
          und_nxt = 1'b0;
          lap_nxt = lap_r | (wp_r == LAST);
          if (wp_adv == rp_r) begin
            ovr_nxt = 1'b1;
          end
        end
        OP_POP: begin
          ovr_nxt = 1'b0;
          rp_nxt  = eff_adv;
          if (eff_adv == wp_r) begin
            und_nxt = 1'b1;
          end
        end
        OP_SET_DIST: begin
          rp_nxt  = set_rp;
          ovr_nxt = 1'b0;
          und_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      und_r <= 1'b1;
      ovr_r <= 1'b0;
      lap_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      und_r <= und_nxt;
      ovr_r <= ovr_nxt;
      lap_r <= lap_nxt;
    end
  end

  // Memory port: write on push, registered read on pop
  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == OP_PUSH) begin
      mem[wp_r] <= smp_r;
    end
    if (cmd.exec && op_r == OP_POP) begin
      rd_r    <= mem[eff];
      rd_ok_r <= lap_r || (eff < wp_r);
    end
  end

  // Output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.sample_out    <= (op_r == OP_POP && rd_ok_r) ? rd_r : '0;
      out_r.fill_distance <= fill_x[DIST_W-1:0];
      out_r.underrun      <= und_r;
      out_r.overrun       <= ovr_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
